// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the wildcard matcher RTL.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_AT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    `ASSERT_AT(label, clk, rst_n, !(cond))
`else
`define ASSERT_AT(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== hw/rtl/wpm_pkg.sv =====
// Package for the wildcard pattern matcher: sizes, wildcard codes and the
// decoded-pattern struct. No dependencies.
`timescale 1ns / 1ps

package wpm_pkg;

    localparam int PatternLen = 64;               // pattern bytes looked at (8..64)
    localparam int PosW       = PatternLen + 1;   // NFA positions incl. pattern end
    localparam int NumWords   = 8;                // 64-bit pattern registers
    localparam int WordW      = 64;
    localparam int ByteW      = 8;
    localparam int CfgAddrW   = 6;                // byte address of 8 x 8-byte regs
    localparam int RegIdxW    = 3;
    localparam int RegIdxLsb  = 3;

    localparam logic [ByteW-1:0] StarChar  = 8'h2A;
    localparam logic [ByteW-1:0] QmarkChar = 8'h3F;
    localparam logic [ByteW-1:0] EosChar   = 8'h00;

    // Pattern after decode, one bit per pattern position.
    typedef struct packed {
        logic [PatternLen-1:0]       in_pat;  // position lies before the pattern end
        logic [PatternLen-1:0]       star;    // '*' inside the pattern
        logic [PatternLen-1:0]       qmark;   // '?' inside the pattern
        logic [PatternLen*ByteW-1:0] bytes;   // literal bytes, position 0 lowest
    } wpm_pat_t;

endpackage

// ===== hw/rtl/wpm_ifs.sv =====
// Valid/ready channel interfaces of the wildcard pattern matcher.
// Depends on wpm_pkg.
`timescale 1ns / 1ps

interface wpm_text_if;
    logic                     valid;
    logic                     ready;
    logic [wpm_pkg::ByteW-1:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

interface wpm_match_if;
    logic valid;
    logic ready;
    logic matched;

    modport source (output valid, output matched, input ready);
    modport sink   (input valid, input matched, output ready);
endinterface

// ===== hw/rtl/wpm_apb_regs.sv =====
// APB register file holding the eight 64-bit pattern words.
// Depends on wpm_pkg.
`timescale 1ns / 1ps

module wpm_apb_regs (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic [wpm_pkg::CfgAddrW-1:0]              paddr,
    input  logic [wpm_pkg::WordW-1:0]                 pwdata,
    output logic [wpm_pkg::WordW-1:0]                 prdata,
    output logic                                      pready,
    output logic [wpm_pkg::NumWords*wpm_pkg::WordW-1:0] pattern
);

    logic [wpm_pkg::NumWords-1:0][wpm_pkg::WordW-1:0] pattern_reg;
    logic [wpm_pkg::NumWords-1:0][wpm_pkg::WordW-1:0] pattern_next;
    logic [wpm_pkg::RegIdxW-1:0]                      reg_idx;
    logic                                             wr_en;

    assign reg_idx = paddr[wpm_pkg::RegIdxLsb +: wpm_pkg::RegIdxW];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign prdata  = pattern_reg[reg_idx];
    assign pattern = pattern_reg;

    always_comb
    begin
        pattern_next = pattern_reg;
        if (wr_en)
        begin
            pattern_next[reg_idx] = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
        end
        else
        begin
            pattern_reg <= pattern_next;
        end
    end

endmodule

// ===== hw/rtl/wpm_pattern_decode.sv =====
// Pattern decode: pattern length mask and wildcard masks from the words.
// Depends on wpm_pkg.
`timescale 1ns / 1ps

module wpm_pattern_decode (
    input  logic [wpm_pkg::NumWords*wpm_pkg::WordW-1:0] pattern,
    output wpm_pkg::wpm_pat_t                           pat
);

    localparam int Levels = $clog2(wpm_pkg::PatternLen);

    logic [Levels:0][wpm_pkg::PatternLen-1:0] pre;
    logic [wpm_pkg::PatternLen-1:0]           nz;
    logic [wpm_pkg::ByteW-1:0]                pb;

    // Prefix AND of "byte is not zero": a position is inside the pattern
    // when no zero byte stands at or before it.
    always_comb
    begin
        for (int i = 0; i < wpm_pkg::PatternLen; i++)
        begin
            nz[i] = |pattern[i*wpm_pkg::ByteW +: wpm_pkg::ByteW];
        end
        pre[0] = nz;
        for (int l = 0; l < Levels; l++)
        begin
            for (int i = 0; i < wpm_pkg::PatternLen; i++)
            begin
                if (i >= (1 << l))
                begin
                    pre[l+1][i] = pre[l][i] & pre[l][i-(1<<l)];
                end
                else
                begin
                    pre[l+1][i] = pre[l][i];
                end
            end
        end
    end

    always_comb
    begin
        pb        = '0;
        pat.in_pat = pre[Levels];
        pat.bytes  = pattern[wpm_pkg::PatternLen*wpm_pkg::ByteW-1:0];
        for (int i = 0; i < wpm_pkg::PatternLen; i++)
        begin
            pb           = pattern[i*wpm_pkg::ByteW +: wpm_pkg::ByteW];
            pat.star[i]  = pre[Levels][i] && (pb == wpm_pkg::StarChar);
            pat.qmark[i] = pre[Levels][i] && (pb == wpm_pkg::QmarkChar);
        end
    end

endmodule

// ===== hw/rtl/wpm_nfa_step.sv =====
// NFA state register with the per-byte update: closure over wildcards,
// character moves and the end-of-pattern test. Depends on wpm_pkg.
`timescale 1ns / 1ps

module wpm_nfa_step (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step_en,
    input  logic [wpm_pkg::ByteW-1:0] text_byte,
    input  wpm_pkg::wpm_pat_t         pat,
    output logic                      matched
);

    localparam int Levels = $clog2(wpm_pkg::PosW);

    logic [wpm_pkg::PosW-1:0]                 active_reg;
    logic [wpm_pkg::PosW-1:0]                 active_next;
    logic [wpm_pkg::PosW-1:0]                 upto;
    logic [wpm_pkg::PosW-1:0]                 end_pos;
    logic [wpm_pkg::PosW-1:0]                 cl;
    logic [wpm_pkg::PosW-1:0]                 nx;
    logic [Levels:0][wpm_pkg::PosW-1:0]       gen;
    logic [Levels:0][wpm_pkg::PosW-1:0]       prop;
    logic                                     eos;

    assign eos = (text_byte == wpm_pkg::EosChar);

    // Positions up to and including the pattern end, and the end itself.
    assign upto    = {pat.in_pat, 1'b1};
    assign end_pos = upto & ~{1'b0, pat.in_pat};

    // Closure as a parallel prefix: a wildcard at i-1 carries position i-1 to i.
    always_comb
    begin
        gen[0]  = active_reg & upto;
        prop[0] = {pat.star | pat.qmark, 1'b0};
        for (int l = 0; l < Levels; l++)
        begin
            for (int i = 0; i < wpm_pkg::PosW; i++)
            begin
                if (i >= (1 << l))
                begin
                    gen[l+1][i]  = gen[l][i] | (prop[l][i] & gen[l][i-(1<<l)]);
                    prop[l+1][i] = prop[l][i] & prop[l][i-(1<<l)];
                end
                else
                begin
                    gen[l+1][i]  = gen[l][i];
                    prop[l+1][i] = prop[l][i];
                end
            end
        end
        cl = gen[Levels];
    end

    // Character moves: '*' holds its position, '?' or an equal byte advances.
    always_comb
    begin
        nx = '0;
        for (int i = 0; i < wpm_pkg::PatternLen; i++)
        begin
            if (cl[i] && pat.star[i])
            begin
                nx[i] = 1'b1;
            end
            if (cl[i] && pat.in_pat[i] && !pat.star[i] &&
                (pat.qmark[i] ||
                 pat.bytes[i*wpm_pkg::ByteW +: wpm_pkg::ByteW] == text_byte))
            begin
                nx[i+1] = 1'b1;
            end
        end
    end

    assign matched = |(cl & end_pos);

    always_comb
    begin
        active_next = active_reg;
        if (step_en)
        begin
            active_next = eos ? wpm_pkg::PosW'(1) : nx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= wpm_pkg::PosW'(1);
        end
        else
        begin
            active_reg <= active_next;
        end
    end

endmodule

// ===== hw/rtl/wildcard_pattern_matcher.sv =====
// Top level of the wildcard pattern matcher: input register, NFA step,
// result register and APB pattern registers. Depends on wpm_pkg, wpm_ifs,
// wpm_apb_regs, wpm_pattern_decode, wpm_nfa_step and assert_macros.svh.
//
//   channel    | role   | word                 | notes
//   -----------+--------+----------------------+-------------------------------
//   text_in    | sink   | text_byte [7:0]      | one subject byte, zero = end
//   match_out  | source | matched              | one word per zero byte
//   apb        | slave  | 64-bit pattern words | reg n at byte address 8*n
//
// Cycles: one byte per cycle sustained while no zero byte waits on an unclaimed
// result; a byte is taken into the input register, and the NFA step consumes
// it from there through the bit-parallel closure and move logic.
// A zero byte loads the result register when the NFA step consumes it.
// Reset: asynchronous, active low; pattern words clear to zero and the NFA
// holds only position zero.
// Stalls: only a zero byte waits, and only while a result is held unclaimed.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wildcard_pattern_matcher (
    input  logic                         clk,
    input  logic                         rst_n,
    wpm_text_if.sink                     text_in,
    wpm_match_if.source                  match_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [wpm_pkg::CfgAddrW-1:0] paddr,
    input  logic [wpm_pkg::WordW-1:0]    pwdata,
    output logic [wpm_pkg::WordW-1:0]    prdata,
    output logic                         pready
);

    logic [wpm_pkg::NumWords*wpm_pkg::WordW-1:0] pattern;
    wpm_pkg::wpm_pat_t                           pat;

    logic                      in_vld_reg;
    logic                      in_vld_next;
    logic [wpm_pkg::ByteW-1:0] in_byte_reg;
    logic [wpm_pkg::ByteW-1:0] in_byte_next;
    logic                      out_vld_reg;
    logic                      out_vld_next;
    logic                      out_match_reg;
    logic                      out_match_next;

    logic                      eos;
    logic                      out_free;
    logic                      consume;
    logic                      step_match;

    // Pattern registers and their decode.
    wpm_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pattern (pattern)
    );

    wpm_pattern_decode u_decode (
        .pattern (pattern),
        .pat     (pat)
    );

    // Handshake: a non-zero byte always drains the input register; a zero
    // byte drains it only when the result register can take its word.
    assign eos      = (in_byte_reg == wpm_pkg::EosChar);
    assign out_free = !out_vld_reg || match_out.ready;
    assign consume  = in_vld_reg && (!eos || out_free);

    assign text_in.ready = !in_vld_reg || consume;

    wpm_nfa_step u_nfa (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (consume),
        .text_byte (in_byte_reg),
        .pat       (pat),
        .matched   (step_match)
    );

    // Input register: refill whenever the held byte leaves or none is held.
    always_comb
    begin
        in_vld_next  = in_vld_reg;
        in_byte_next = in_byte_reg;
        if (text_in.ready)
        begin
            in_vld_next = text_in.valid;
            if (text_in.valid)
            begin
                in_byte_next = text_in.text_byte;
            end
        end
    end

    // Result register: load on a consumed zero byte, drop once taken.
    always_comb
    begin
        out_vld_next   = out_vld_reg;
        out_match_next = out_match_reg;
        if (consume && eos)
        begin
            out_vld_next   = 1'b1;
            out_match_next = step_match;
        end
        else if (match_out.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_byte_reg   <= in_byte_next;
        out_match_reg <= out_match_next;
    end

    assign match_out.valid   = out_vld_reg;
    assign match_out.matched = out_match_reg;

    // A result appears only after a zero byte went through the NFA step.
    `ASSERT_AT(a_result_from_eos, clk, rst_n,
        $rose(out_vld_reg) |-> $past(consume && eos))
    // A byte that is not consumed stays in the input register unchanged.
    `ASSERT_AT(a_input_held, clk, rst_n,
        (in_vld_reg && !consume) |=> (in_vld_reg && $stable(in_byte_reg)))
    // An unclaimed result is never overwritten by a later zero byte.
    `ASSERT_NEVER(a_no_overwrite, clk, rst_n,
        out_vld_reg && !match_out.ready && consume && eos)

endmodule
